// ===== hdl/multichannel_signal_loss_watchdog_assert.svh =====
// Assertion macros for the signal loss watchdog.
// Simulation builds get the checks; synthesis builds see empty bodies.
`ifndef MULTICHANNEL_SIGNAL_LOSS_WATCHDOG_ASSERT_SVH
`define MULTICHANNEL_SIGNAL_LOSS_WATCHDOG_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted.
`define SWD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define SWD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SWD_ASSERT(lbl, clk, rstn, prop, msg)
`define SWD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/swd_pkg.sv =====
package swd_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MASK_W   = (CHANNELS < 8) ? CHANNELS : 8;

    localparam int SAMPLE_W = 10;
    localparam int LOSS_W   = 9;
    localparam int CNT_W    = 8;
    localparam int REBOOT_W = 4;
    localparam int OUT_CH_W = 3;

    localparam logic [LOSS_W-1:0]   LOSS_MAX   = '1;
    localparam logic [REBOOT_W-1:0] REBOOT_MAX = '1;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_LEVEL_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_LOSS_LIMIT      = 3'd1;
    localparam logic [2:0] CFG_PULSE_LENGTH    = 3'd2;
    localparam logic [2:0] CFG_REBOOT_WAIT     = 3'd3;
    localparam logic [2:0] CFG_GIVEUP_COUNT    = 3'd4;

    // Reset values
    localparam logic [SAMPLE_W-1:0] RST_LEVEL_THRESHOLD = 10'd20;
    localparam logic [CNT_W-1:0]    RST_LOSS_LIMIT      = 8'd40;
    localparam logic [CNT_W-1:0]    RST_PULSE_LENGTH    = 8'd5;
    localparam logic [CNT_W-1:0]    RST_REBOOT_WAIT     = 8'd40;
    localparam logic [REBOOT_W-1:0] RST_GIVEUP_COUNT    = 4'd3;

    typedef logic [CH_W-1:0] chan_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level_threshold;
        logic [CNT_W-1:0]    loss_limit;
        logic [CNT_W-1:0]    pulse_length;
        logic [CNT_W-1:0]    reboot_wait;
        logic [REBOOT_W-1:0] giveup_count;
    } cfg_t;

    // One classified item travelling from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] level_sample;
        logic                channel_enabled;
        chan_t               channel;
        chan_t               next_channel;
        logic                blink;
    } cmd_t;

    typedef struct packed {
        logic [OUT_CH_W-1:0] served_channel;
        logic                relay_on;
        logic                signal_present;
        logic                pulsing;
        logic                waiting_reboot;
        logic                gave_up;
        logic [7:0]          relay_mask;
        logic [OUT_CH_W-1:0] next_channel;
        logic                blink_phase;
    } result_t;

    function automatic logic [OUT_CH_W-1:0] chan_to_out(input chan_t ch);
        logic [OUT_CH_W+CH_W-1:0] wide;
        wide = {{OUT_CH_W{1'b0}}, ch};
        return wide[OUT_CH_W-1:0];
    endfunction

endpackage

// ===== hdl/swd_front.sv =====
// Round-robin channel sequencer: tags each accepted item with its channel.
module swd_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [swd_pkg::SAMPLE_W-1:0]       s_level_sample,
    input  logic                               s_channel_enabled,
    input  logic                               q_full,
    output logic                               q_push,
    output swd_pkg::cmd_t                      q_cmd
);

    swd_pkg::chan_t chan_reg, chan_next;
    logic           blink_reg, blink_next;
    swd_pkg::chan_t succ;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        if (chan_reg >= swd_pkg::chan_t'(swd_pkg::CHANNELS - 1)) begin
            succ = '0;
        end else begin
            succ = chan_reg + swd_pkg::chan_t'(1);
        end
        chan_next  = q_push ? succ : chan_reg;
        blink_next = q_push ? !blink_reg : blink_reg;

        q_cmd.level_sample    = s_level_sample;
        q_cmd.channel_enabled = s_channel_enabled;
        q_cmd.channel         = chan_reg;
        q_cmd.next_channel    = succ;
        q_cmd.blink           = !blink_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg  <= '0;
            blink_reg <= 1'b0;
        end else begin
            chan_reg  <= chan_next;
            blink_reg <= blink_next;
        end
    end

endmodule

// ===== hdl/swd_queue.sv =====
// Two-entry queue between sequencer and channel engine.
module swd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  swd_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output swd_pkg::cmd_t head
);

    swd_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/swd_back.sv =====
`include "multichannel_signal_loss_watchdog_assert.svh"

// Channel engine: read-modify-write of one channel record per item,
// result held in an output register.
module swd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  swd_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  swd_pkg::cmd_t    q_cmd,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output swd_pkg::result_t m_result
);

    logic                          relay_reg  [swd_pkg::CHANNELS];
    logic                          signal_reg [swd_pkg::CHANNELS];
    logic [swd_pkg::LOSS_W-1:0]    loss_reg   [swd_pkg::CHANNELS];
    logic [swd_pkg::CNT_W-1:0]     pulse_reg  [swd_pkg::CHANNELS];
    logic [swd_pkg::CNT_W-1:0]     wait_reg   [swd_pkg::CHANNELS];
    logic [swd_pkg::REBOOT_W-1:0]  reboot_reg [swd_pkg::CHANNELS];

    logic                          relay_next;
    logic                          signal_next;
    logic [swd_pkg::LOSS_W-1:0]    loss_next;
    logic [swd_pkg::CNT_W-1:0]     pulse_next;
    logic [swd_pkg::CNT_W-1:0]     wait_next;
    logic [swd_pkg::REBOOT_W-1:0]  reboot_next;

    logic             out_valid_reg, out_valid_next;
    swd_pkg::result_t result_reg, result_next;
    swd_pkg::chan_t   ch;
    logic [7:0]       mask;

    assign q_pop    = q_valid && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_result = result_reg;
    assign ch       = q_cmd.channel;

    always_comb begin
        relay_next  = relay_reg[ch];
        signal_next = signal_reg[ch];
        loss_next   = loss_reg[ch];
        pulse_next  = pulse_reg[ch];
        wait_next   = wait_reg[ch];
        reboot_next = reboot_reg[ch];

        if (!q_cmd.channel_enabled) begin
            relay_next  = 1'b0;
            signal_next = 1'b0;
            loss_next   = '0;
            pulse_next  = '0;
            wait_next   = '0;
            reboot_next = '0;
        end else if (reboot_reg[ch] >= cfg.giveup_count) begin
            // held idle, reboot count kept
            relay_next  = 1'b0;
            signal_next = 1'b0;
            loss_next   = '0;
            pulse_next  = '0;
            wait_next   = '0;
        end else begin
            if (pulse_reg[ch] == '0 && wait_reg[ch] == '0) begin
                relay_next = 1'b0;
                if (q_cmd.level_sample < cfg.level_threshold) begin
                    signal_next = 1'b0;
                    if (loss_reg[ch] != swd_pkg::LOSS_MAX) begin
                        loss_next = loss_reg[ch] + swd_pkg::LOSS_W'(1);
                    end
                end else begin
                    signal_next = 1'b1;
                    loss_next   = '0;
                end
                if (loss_next > {1'b0, cfg.loss_limit}) begin
                    pulse_next = cfg.pulse_length;
                    wait_next  = cfg.reboot_wait;
                    loss_next  = '0;
                    if (reboot_reg[ch] != swd_pkg::REBOOT_MAX) begin
                        reboot_next = reboot_reg[ch] + swd_pkg::REBOOT_W'(1);
                    end
                end
            end
            if (pulse_next != '0) begin
                relay_next = 1'b1;
                pulse_next = pulse_next - swd_pkg::CNT_W'(1);
            end else if (wait_next != '0) begin
                relay_next = 1'b0;
                wait_next  = wait_next - swd_pkg::CNT_W'(1);
            end
        end

        mask = '0;
        for (int i = 0; i < swd_pkg::MASK_W; i++) begin
            mask[i] = (swd_pkg::chan_t'(i) == ch) ? relay_next : relay_reg[i];
        end

        result_next.served_channel = swd_pkg::chan_to_out(ch);
        result_next.relay_on       = relay_next;
        result_next.signal_present = signal_next;
        result_next.pulsing        = (pulse_next != '0);
        result_next.waiting_reboot = (wait_next != '0);
        result_next.gave_up        = (reboot_next >= cfg.giveup_count);
        result_next.relay_mask     = mask;
        result_next.next_channel   = swd_pkg::chan_to_out(q_cmd.next_channel);
        result_next.blink_phase    = q_cmd.blink;

        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < swd_pkg::CHANNELS; i++) begin
                relay_reg[i]  <= 1'b0;
                signal_reg[i] <= 1'b0;
                loss_reg[i]   <= '0;
                pulse_reg[i]  <= '0;
                wait_reg[i]   <= '0;
                reboot_reg[i] <= '0;
            end
        end else if (q_pop) begin
            relay_reg[ch]  <= relay_next;
            signal_reg[ch] <= signal_next;
            loss_reg[ch]   <= loss_next;
            pulse_reg[ch]  <= pulse_next;
            wait_reg[ch]   <= wait_next;
            reboot_reg[ch] <= reboot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            result_reg <= result_next;
        end
    end

    `SWD_ASSERT(a_pop_fills_out, aclk, aresetn, q_pop |=> out_valid_reg, "popped item lost")
    `SWD_ASSERT(a_pulse_relay, aclk, aresetn, (out_valid_reg && result_reg.pulsing) |-> result_reg.relay_on, "pulsing with relay off")
    `SWD_ASSERT(a_disabled_idle, aclk, aresetn, (q_pop && !q_cmd.channel_enabled) |=> (!result_reg.relay_on && !result_reg.pulsing && !result_reg.waiting_reboot), "disabled channel not cleared")
    `SWD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !out_valid_reg, "result valid after reset")

endmodule

// ===== hdl/multichannel_signal_loss_watchdog.sv =====
// Channel   | Direction | Handshake         | Payload
// ----------+-----------+-------------------+-------------------------------------------
// s_        | in        | s_valid/s_ready   | level_sample, channel_enabled
// m_        | out       | m_valid/m_ready   | served_channel .. blink_phase (9 fields)
// cfg_      | in        | cfg_wr_en only    | cfg_addr, cfg_wdata (5 registers)
//
// One item per cycle sustained while m_ready holds; an item's result is registered first
// in a queue entry at the accept edge and then in the output register. The rate is
// set by the read-modify-write of the served channel's record in the
// channel engine.
// aresetn is synchronous, active low; it clears all channel records, the
// round-robin pointer, the blink flag and the registers to their defaults.
// A stalled m_ready fills the 2-entry queue, after which s_ready drops.
module multichannel_signal_loss_watchdog (
    input  logic                         aclk,
    input  logic                         aresetn,

    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_addr,
    input  logic [swd_pkg::SAMPLE_W-1:0] cfg_wdata,

    // input items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [swd_pkg::SAMPLE_W-1:0] s_level_sample,
    input  logic                         s_channel_enabled,

    // result items
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_served_channel,
    output logic                         m_relay_on,
    output logic                         m_signal_present,
    output logic                         m_pulsing,
    output logic                         m_waiting_reboot,
    output logic                         m_gave_up,
    output logic [7:0]                   m_relay_mask,
    output logic [2:0]                   m_next_channel,
    output logic                         m_blink_phase
);

    swd_pkg::cfg_t    cfg_reg, cfg_next;

    // front -> queue
    logic             q_push;
    swd_pkg::cmd_t    q_push_cmd;
    logic             q_full;

    // queue -> back
    logic             q_pop;
    logic             q_valid;
    swd_pkg::cmd_t    q_head;

    swd_pkg::result_t result;

    // Register file: writes to unknown indexes are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                swd_pkg::CFG_LEVEL_THRESHOLD: cfg_next.level_threshold = cfg_wdata;
                swd_pkg::CFG_LOSS_LIMIT:      cfg_next.loss_limit      = cfg_wdata[7:0];
                swd_pkg::CFG_PULSE_LENGTH:    cfg_next.pulse_length    = cfg_wdata[7:0];
                swd_pkg::CFG_REBOOT_WAIT:     cfg_next.reboot_wait     = cfg_wdata[7:0];
                swd_pkg::CFG_GIVEUP_COUNT:    cfg_next.giveup_count    = cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.level_threshold <= swd_pkg::RST_LEVEL_THRESHOLD;
            cfg_reg.loss_limit      <= swd_pkg::RST_LOSS_LIMIT;
            cfg_reg.pulse_length    <= swd_pkg::RST_PULSE_LENGTH;
            cfg_reg.reboot_wait     <= swd_pkg::RST_REBOOT_WAIT;
            cfg_reg.giveup_count    <= swd_pkg::RST_GIVEUP_COUNT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: tags items with channel, successor and blink phase.
    swd_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_level_sample    (s_level_sample),
        .s_channel_enabled (s_channel_enabled),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_cmd             (q_push_cmd)
    );

    // Decoupling queue so front and back stall independently.
    swd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // Back: per-channel watchdog state and the result register.
    swd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_served_channel = result.served_channel;
    assign m_relay_on       = result.relay_on;
    assign m_signal_present = result.signal_present;
    assign m_pulsing        = result.pulsing;
    assign m_waiting_reboot = result.waiting_reboot;
    assign m_gave_up        = result.gave_up;
    assign m_relay_mask     = result.relay_mask;
    assign m_next_channel   = result.next_channel;
    assign m_blink_phase    = result.blink_phase;

endmodule
